### rtl/mcalu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcalu_pkg
// Shared types and codes for the multicycle integer alu.
// ----------------------------------------------------------------------------
package mcalu_pkg;

    localparam int unsigned OpWidth = 3;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4,
        OP_MOD = 3'd5,
        OP_RS6 = 3'd6,
        OP_RS7 = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_RUN,
        ST_FINISH,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
    } t_status;

endpackage

### rtl/multicycle_integer_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multicycle_integer_alu_top
// Integer alu: add, subtract, multiply, divide, power, modulo.
// ----------------------------------------------------------------------------
// sequence: load, start, the iteration steps, finish and the result handshake;
// power runs more iteration steps than the other operations
// a new input beat is taken only in idle, once the previous result has been accepted
// one shift/subtract or multiply step per cycle in the datapath
// synchronous active-low reset returns the sequencer to idle
module multicycle_integer_alu_top #(
    parameter int unsigned WORD_WIDTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic [mcalu_pkg::OpWidth-1:0] i_operation,
    input  logic signed [WORD_WIDTH-1:0] i_operand_a,
    input  logic signed [WORD_WIDTH-1:0] i_operand_b,
    output logic o_out_valid,
    input  logic i_out_stall,
    output logic signed [WORD_WIDTH-1:0] o_result_word,
    output logic o_divide_by_zero
);

    mcalu_pkg::t_cmd    cmd;
    mcalu_pkg::t_status status;
    logic [WORD_WIDTH-1:0] res;

    mcalu_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .o_out_valid, .i_out_stall,
        .o_cmd(cmd), .i_status(status)
    );

    mcalu_dp #(.WORD_WIDTH(WORD_WIDTH)) u_dp (
        .i_clk, .i_cmd(cmd), .o_status(status), .i_op(i_operation),
        .i_a(i_operand_a), .i_b(i_operand_b), .o_result(res), .o_dz(o_divide_by_zero)
    );

    assign o_result_word = res;

endmodule

### rtl/mcalu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcalu_ctrl
// Sequencer: load, iterate the datapath, then hold the result beat.
// ----------------------------------------------------------------------------
module mcalu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mcalu_pkg::t_cmd    o_cmd,
    input  mcalu_pkg::t_status i_status
);

    mcalu_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcalu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        o_out_valid  = 1'b0;
        unique case (r_state)
            mcalu_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mcalu_pkg::ST_START;
                end
            end
            mcalu_pkg::ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = mcalu_pkg::ST_RUN;
            end
            mcalu_pkg::ST_RUN: begin
                o_cmd.step = 1'b1;
                if (i_status.last) n_state = mcalu_pkg::ST_FINISH;
            end
            mcalu_pkg::ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = mcalu_pkg::ST_OUT;
            end
            mcalu_pkg::ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) n_state = mcalu_pkg::ST_IDLE;
            end
            default: n_state = mcalu_pkg::ST_IDLE;
        endcase
    end

    // result beat only after finish
    a_out_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_cmd.finish))
        else $error("result valid without finish");
    // load only when idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_out_valid)
        else $error("load while result pending");
    // start follows load
    a_start_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.start)
        else $error("start missing after load");

endmodule

### rtl/mcalu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcalu_dp
// Datapath: shift-add multiply, restoring divide, square-and-multiply power.
// ----------------------------------------------------------------------------
module mcalu_dp #(
    parameter int unsigned WORD_WIDTH = 16
) (
    input  logic                            i_clk,
    input  mcalu_pkg::t_cmd                 i_cmd,
    output mcalu_pkg::t_status              o_status,
    input  logic [mcalu_pkg::OpWidth-1:0]   i_op,
    input  logic [WORD_WIDTH-1:0]           i_a,
    input  logic [WORD_WIDTH-1:0]           i_b,
    output logic [WORD_WIDTH-1:0]           o_result,
    output logic                            o_dz
);

    localparam int unsigned CntW = $clog2(WORD_WIDTH);
    localparam int unsigned PowSteps = 2 * WORD_WIDTH;
    localparam int unsigned PcW = $clog2(PowSteps);
    localparam logic [PcW-1:0] LastPow = PcW'(PowSteps - 1);
    localparam logic [PcW-1:0] LastW = PcW'(WORD_WIDTH - 1);
    localparam logic [WORD_WIDTH-1:0] One = WORD_WIDTH'(1);

    mcalu_pkg::t_op        r_op;
    logic [WORD_WIDTH-1:0] r_a, r_b;
    logic [WORD_WIDTH-1:0] r_acc, r_x, r_y, r_rem, r_res;
    logic [WORD_WIDTH-1:0] r_pa, r_pb;
    logic [PcW-1:0]        r_cnt;
    logic                  r_dz;

    logic                  sa, sb;
    logic [WORD_WIDTH-1:0] ma, mb;
    logic [WORD_WIDTH:0]   trial;
    logic [WORD_WIDTH-1:0] mul_b, prod, qneg, rneg;
    logic [CntW-1:0]       bit_idx;

    assign sa = r_a[WORD_WIDTH-1];
    assign sb = r_b[WORD_WIDTH-1];
    assign ma = sa ? (~r_a + One) : r_a;
    assign mb = sb ? (~r_b + One) : r_b;
    assign bit_idx = r_cnt[PcW-1:1];
    // restoring divide trial subtract
    assign trial = {r_rem[WORD_WIDTH-2:0], r_x[WORD_WIDTH-1]} - {1'b0, r_y};
    // one shared multiplier for power: acc*base on even steps, base squared on odd
    assign mul_b = r_cnt[0] ? r_pb : r_pa;
    assign prod = r_pb * mul_b;
    assign qneg = ~r_acc + One;
    assign rneg = ~r_rem + One;

    always_comb begin
        o_status.last = 1'b0;
        unique case (r_op)
            mcalu_pkg::OP_POW: o_status.last = (r_cnt == LastPow);
            default:           o_status.last = (r_cnt == LastW);
        endcase
    end

    // iterative datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= mcalu_pkg::t_op'(i_op);
            r_a  <= i_a;
            r_b  <= i_b;
        end
        if (i_cmd.start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_acc <= One;
            unique case (r_op)
                mcalu_pkg::OP_MUL: begin
                    r_acc <= '0;
                    r_x   <= r_a;
                    r_y   <= r_b;
                end
                mcalu_pkg::OP_DIV, mcalu_pkg::OP_MOD: begin
                    r_acc <= '0;
                    r_x   <= ma;
                    r_y   <= mb;
                end
                default: begin
                    r_x <= r_a;
                    r_y <= One;
                end
            endcase
        end
        if (i_cmd.step) begin
            r_cnt <= r_cnt + PcW'(1);
            unique case (r_op)
                mcalu_pkg::OP_MUL: begin
                    if (r_y[0]) r_acc <= r_acc + r_x;
                    r_x <= r_x << 1;
                    r_y <= r_y >> 1;
                end
                mcalu_pkg::OP_DIV, mcalu_pkg::OP_MOD: begin
                    r_x <= r_x << 1;
                    if (!trial[WORD_WIDTH] || r_rem[WORD_WIDTH-1]) begin
                        r_rem <= trial[WORD_WIDTH-1:0];
                        r_acc <= {r_acc[WORD_WIDTH-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[WORD_WIDTH-2:0], r_x[WORD_WIDTH-1]};
                        r_acc <= {r_acc[WORD_WIDTH-2:0], 1'b0};
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.finish) begin
            r_dz  <= 1'b0;
            r_res <= '0;
            unique case (r_op)
                mcalu_pkg::OP_ADD: r_res <= r_a + r_b;
                mcalu_pkg::OP_SUB: r_res <= r_a - r_b;
                mcalu_pkg::OP_MUL: r_res <= r_acc;
                mcalu_pkg::OP_DIV: begin
                    if (r_b == '0) r_dz <= 1'b1;
                    else r_res <= (sa ^ sb) ? qneg : r_acc;
                end
                mcalu_pkg::OP_MOD: begin
                    if (r_b == '0) r_dz <= 1'b1;
                    else r_res <= sa ? rneg : r_rem;
                end
                mcalu_pkg::OP_POW: begin
                    if (r_b == '0) r_res <= One;
                    else if (sb) begin
                        if (r_a == One) r_res <= One;
                        else if (r_a == '1) r_res <= r_b[0] ? '1 : One;
                        else r_res <= '0;
                    end else r_res <= r_pa;
                end
                default: ;
            endcase
        end
    end

    // power accumulator and base, one exponent bit per two steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pa <= One;
            r_pb <= r_a;
        end else if (i_cmd.step && r_op == mcalu_pkg::OP_POW) begin
            if (!r_cnt[0]) begin
                if (r_b[bit_idx]) r_pa <= prod;
            end else begin
                r_pb <= prod;
            end
        end
    end

    assign o_result = r_res;
    assign o_dz = r_dz;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multicycle integer alu: directed corner beats,
// then random operations with random idling on both sides and a long output
// hold-off, each result checked in order against an internal predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned W = 16;
    localparam int unsigned NUM_RANDOM = 1630;
    localparam logic [W-1:0] MSB = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ALL1 = {W{1'b1}};
    localparam logic [W-1:0] ONE = W'(1);

    typedef struct packed {
        mcalu_pkg::t_op op;
        logic [W-1:0]   a;
        logic [W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [W-1:0]  word;
        logic          dz;
    } t_alu_rsp;

    // predicted alu result for one request beat
    function automatic t_alu_rsp alu_predict(t_alu_req q);
        t_alu_rsp r;
        logic [W-1:0] ma, mb, qv, acc, base;
        r = '0;
        ma = q.a[W-1] ? -q.a : q.a;
        mb = q.b[W-1] ? -q.b : q.b;
        case (q.op)
            mcalu_pkg::OP_ADD: r.word = q.a + q.b;
            mcalu_pkg::OP_SUB: r.word = q.a - q.b;
            mcalu_pkg::OP_MUL: r.word = q.a * q.b;
            mcalu_pkg::OP_DIV, mcalu_pkg::OP_MOD: begin
                if (q.b == '0) begin
                    r.dz = 1'b1;
                end else if (q.op == mcalu_pkg::OP_DIV) begin
                    qv = ma / mb;
                    r.word = (q.a[W-1] ^ q.b[W-1]) ? -qv : qv;
                end else begin
                    qv = ma % mb;
                    r.word = q.a[W-1] ? -qv : qv;
                end
            end
            mcalu_pkg::OP_POW: begin
                if (q.b == '0) r.word = ONE;
                else if (q.b[W-1]) begin
                    if (q.a == ONE) r.word = ONE;
                    else if (q.a == ALL1) r.word = q.b[0] ? ALL1 : ONE;
                    else r.word = '0;
                end else if (q.a == '0) r.word = '0;
                else begin
                    acc = ONE;
                    base = q.a;
                    for (int i = 0; i < W; i++) begin
                        if (q.b[i]) acc = acc * base;
                        base = base * base;
                    end
                    r.word = acc;
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // in-order store of predicted results
    class alu_scoreboard;
        t_alu_rsp pending[$];
        int errors = 0;
        int checked = 0;
        int op_count[8];

        function void note_request(t_alu_req q);
            pending.push_back(alu_predict(q));
            op_count[q.op]++;
        endfunction

        function void check_result(t_alu_rsp got);
            t_alu_rsp want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.word !== want.word || got.dz !== want.dz) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected word %h dz %b, got word %h dz %b",
                             want.word, want.dz, got.word, got.dz);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_in_valid, o_in_stall, o_out_valid, i_out_stall;
    logic [2:0] i_operation;
    logic signed [W-1:0] i_operand_a, i_operand_b, o_result_word;
    logic o_divide_by_zero;

    alu_scoreboard sb;
    bit no_idle = 0;
    bit hold_out = 0;

    multicycle_integer_alu_top #(.WORD_WIDTH(W)) u_top (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // drive one request beat, with an optional idle gap first
    task automatic send_req(t_alu_req q);
        if (!no_idle && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= q.op;
        i_operand_a <= q.a;
        i_operand_b <= q.b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(q);
    endtask

    function automatic logic [W-1:0] rand_word();
        case ($urandom_range(5))
            0: return MSB;
            1: return ALL1;
            2: return logic'($urandom_range(1)) ? 16'd1 : 16'd0;
            3: return W'($urandom_range(7)) - W'(3);
            default: return W'($urandom);
        endcase
    endfunction

    // output side: random stall, plus the hold-off window
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b1;
        end else begin
            if (o_out_valid && !i_out_stall)
                sb.check_result('{word: o_result_word, dz: o_divide_by_zero});
            i_out_stall <= hold_out || (!no_idle && $urandom_range(99) < 30);
        end
    end

    initial begin
        t_alu_req q;
        logic [W-1:0] corner_a[6] = '{16'h0000, 16'h0001, ALL1, MSB, 16'h7fff, 16'h0002};
        int cyc;
        sb = new();
        i_rst_n = 0;
        i_in_valid = 0;
        i_operation = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        q = '{mcalu_pkg::OP_DIV, MSB, ALL1};  send_req(q);
        q = '{mcalu_pkg::OP_MOD, MSB, ALL1};  send_req(q);
        q = '{mcalu_pkg::OP_DIV, 16'h1234, '0}; send_req(q);
        q = '{mcalu_pkg::OP_MOD, MSB, '0};    send_req(q);
        q = '{mcalu_pkg::OP_POW, '0, '0};     send_req(q);
        q = '{mcalu_pkg::OP_POW, ALL1, MSB};  send_req(q);
        q = '{mcalu_pkg::OP_POW, ALL1, ALL1}; send_req(q);
        q = '{mcalu_pkg::OP_POW, 16'd1, 16'hfffe}; send_req(q);
        q = '{mcalu_pkg::OP_POW, 16'd5, ALL1}; send_req(q);
        q = '{mcalu_pkg::OP_POW, '0, 16'd7};  send_req(q);
        q = '{mcalu_pkg::OP_POW, 16'd3, 16'h7fff}; send_req(q);
        q = '{mcalu_pkg::OP_RS6, ALL1, ALL1}; send_req(q);
        q = '{mcalu_pkg::OP_RS7, MSB, 16'd3}; send_req(q);
        for (int i = 0; i < 6; i++) begin
            q = '{mcalu_pkg::t_op'(i), corner_a[i], corner_a[5 - i]};
            send_req(q);
        end
        q = '{mcalu_pkg::OP_MUL, 16'h7fff, 16'h7fff}; send_req(q);
        q = '{mcalu_pkg::OP_DIV, 16'hfff9, 16'd2}; send_req(q);
        q = '{mcalu_pkg::OP_MOD, 16'hfff9, 16'hfffe}; send_req(q);

        // long output hold-off while requests keep coming
        fork
            begin
                hold_out = 1;
                for (int k = 0; k < 400; k++) @(posedge i_clk);
                hold_out = 0;
            end
        join_none

        for (int n = 0; n < NUM_RANDOM; n++) begin
            no_idle = (n >= 600 && n < 800);
            q.op = mcalu_pkg::t_op'($urandom_range(9) < 9 ? $urandom_range(5)
                                                          : $urandom_range(7));
            q.a = rand_word();
            q.b = rand_word();
            send_req(q);
        end
        i_in_valid <= 1'b0;
        no_idle = 0;

        cyc = 0;
        while (sb.pending.size() != 0 && cyc < 100000) begin
            @(posedge i_clk);
            cyc++;
        end
        repeat (2 * W + 10) @(posedge i_clk);
        $display("checked %0d results in order, with input gaps and a long output hold-off",
                 sb.checked);
        $display("beats per op add/sub/mul/div/pow/mod/unused: %0d %0d %0d %0d %0d %0d %0d",
                 sb.op_count[0], sb.op_count[1], sb.op_count[2],
                 sb.op_count[3], sb.op_count[4], sb.op_count[5],
                 sb.op_count[6] + sb.op_count[7]);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
